// ----- rtl/core/itp_pkg.sv -----
package itp_pkg;

  localparam int unsigned StackDepth = 32;
  localparam int unsigned StackAw = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned StackLw = $clog2(StackDepth + 1);

  localparam int unsigned PrioW = 24;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgInPrio = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgStackPrio = 1'b1;

  localparam logic [PrioW-1:0] InPrioReset = 24'd2307416;
  localparam logic [PrioW-1:0] StackPrioReset = 24'd1328743;

  localparam logic [3:0] KindPow = 4'd0;
  localparam logic [3:0] KindAssign = 4'd5;
  localparam logic [3:0] KindLparen = 4'd6;
  localparam logic [3:0] KindRparen = 4'd7;
  localparam logic [3:0] KindOperand = 4'd8;
  localparam logic [3:0] KindEnd = 4'd10;

  localparam logic [2:0] StackLparen = 3'd6;
  localparam logic [2:0] StackLastOp = 3'd5;

  localparam logic [3:0] OutOperand = 4'd6;
  localparam logic [3:0] OutEnd = 4'd7;
  localparam logic [3:0] OutError = 4'd8;

  localparam logic [3:0] ErrOk = 4'd0;
  localparam logic [3:0] ErrOpUnexpected = 4'd1;
  localparam logic [3:0] ErrNoLparen = 4'd2;
  localparam logic [3:0] ErrEmptyParens = 4'd3;
  localparam logic [3:0] ErrUnmatched = 4'd4;
  localparam logic [3:0] ErrOperandUnexpected = 4'd5;
  localparam logic [3:0] ErrIllegal = 4'd6;
  localparam logic [3:0] ErrEmpty = 4'd7;
  localparam logic [3:0] ErrOpEnds = 4'd8;
  localparam logic [3:0] ErrNoRparen = 4'd9;
  localparam logic [3:0] ErrOverflow = 4'd10;

  typedef enum logic [1:0] {
    ClsNone   = 2'd0,
    ClsLparen = 2'd1,
    ClsRparen = 2'd2,
    ClsOther  = 2'd3
  } cls_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] operand_ref;
    logic [3:0]  err;
  } result_t;

  function automatic logic [3:0] prio_nibble(logic [PrioW-1:0] tbl, logic [2:0] code);
    logic [3:0] nib;
    case (code)
      3'd0:    nib = tbl[3:0];
      3'd1:    nib = tbl[7:4];
      3'd2:    nib = tbl[11:8];
      3'd3:    nib = tbl[15:12];
      3'd4:    nib = tbl[19:16];
      3'd5:    nib = tbl[23:20];
      3'd6:    nib = tbl[3:0];
      default: nib = tbl[7:4];
    endcase
    return nib;
  endfunction

endpackage

// ----- rtl/core/infix_to_postfix_converter.sv -----
// Shunting-yard converter from classified infix tokens to postfix order. An item is taken
// only when the block is idle; the run state then works the token off, popping operators
// one at a time; a flush state follows when pops come before the token's final result.
// The operator stack sits in a single-port-write, registered-read RAM whose read address
// follows the next stack level, so one entry is popped per cycle while the output is free.
// Result items leave through one output register with a one-entry staging register ahead
// of it, which holds each result until it is known whether it is the last one of its item.
module infix_to_postfix_converter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [itp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [itp_pkg::PrioW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [3:0]                    token_kind_i,
  input  logic [15:0]                   operand_ref_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [3:0]                    out_kind_o,
  output logic [15:0]                   out_operand_ref_o,
  output logic [3:0]                    error_code_o,
  output logic                          last_o
);

  localparam int unsigned Aw = itp_pkg::StackAw;
  localparam int unsigned Lw = itp_pkg::StackLw;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StRun   = 3'b010,
    StFlush = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [itp_pkg::PrioW-1:0] in_prio_q, stack_prio_q;

  logic [3:0]  tok_kind_q;
  logic [15:0] tok_ref_q;

  logic [Lw-1:0]   level_q, level_d;
  logic [Lw-1:0]   open_q, open_d;
  logic            last_op_q, last_op_d;
  itp_pkg::cls_e   prev_q, prev_d;
  logic            seen_q, seen_d;
  logic            discard_q, discard_d;

  itp_pkg::result_t hold_q, hold_d;
  logic             hold_valid_q, hold_valid_d;
  itp_pkg::result_t out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic             out_last_q, out_last_d;

  logic          we;
  logic [2:0]    wdata;
  logic [Aw-1:0] raddr;
  logic [2:0]    top;

  logic       in_acc;
  logic       out_free;
  logic       nonempty;
  logic       full;
  logic [3:0] ip;
  logic [3:0] sp;

  logic             emit_mid;
  logic             emit_final;
  logic             finish_quiet;
  itp_pkg::result_t mid_res;
  itp_pkg::result_t final_res;
  logic             fail;
  logic             fail_at_end;
  logic [3:0]       fail_code;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign nonempty    = (level_q != '0);
  assign full        = (level_q == Lw'(itp_pkg::StackDepth));
  assign ip          = itp_pkg::prio_nibble(in_prio_q, tok_kind_q[2:0]);
  assign sp          = itp_pkg::prio_nibble(stack_prio_q, top);

  assign out_valid_o       = out_valid_q;
  assign out_kind_o        = out_q.kind;
  assign out_operand_ref_o = out_q.operand_ref;
  assign error_code_o      = out_q.err;
  assign last_o            = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_prio_q    <= itp_pkg::InPrioReset;
      stack_prio_q <= itp_pkg::StackPrioReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == itp_pkg::CfgInPrio) begin
        in_prio_q <= cfg_data_i;
      end
      if (cfg_index_i == itp_pkg::CfgStackPrio) begin
        stack_prio_q <= cfg_data_i;
      end
    end
  end

  itp_stack_ram #(
    .Depth(itp_pkg::StackDepth),
    .Width(3),
    .Aw   (Aw)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(level_q[Aw-1:0]),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(top)
  );

  // Track the top of stack: read at the level the next cycle will hold
  always_comb begin
    logic [Lw-1:0] top_idx;
    top_idx = level_d - Lw'(1);
    raddr   = top_idx[Aw-1:0];
  end

  always_comb begin
    level_d      = level_q;
    open_d       = open_q;
    last_op_d    = last_op_q;
    prev_d       = prev_q;
    seen_d       = seen_q;
    discard_d    = discard_q;
    we           = 1'b0;
    wdata        = tok_kind_q[2:0];
    emit_mid     = 1'b0;
    emit_final   = 1'b0;
    finish_quiet = 1'b0;
    mid_res      = '{kind: {1'b0, top}, operand_ref: 16'd0, err: itp_pkg::ErrOk};
    final_res    = '{kind: itp_pkg::OutEnd, operand_ref: 16'd0, err: itp_pkg::ErrOk};
    fail         = 1'b0;
    fail_at_end  = 1'b0;
    fail_code    = itp_pkg::ErrOk;

    if ((state_q == StRun) && out_free) begin
      if (discard_q) begin
        if (tok_kind_q == itp_pkg::KindEnd) begin
          discard_d = 1'b0;
        end
        finish_quiet = 1'b1;
      end else begin
        case (tok_kind_q) inside
          [itp_pkg::KindPow:itp_pkg::KindAssign]: begin
            if (!last_op_q || !seen_q || (prev_q == itp_pkg::ClsLparen)) begin
              fail      = 1'b1;
              fail_code = itp_pkg::ErrOpUnexpected;
            end else if (nonempty && (top <= itp_pkg::StackLastOp) && (ip <= sp)) begin
              emit_mid = 1'b1;
              level_d  = level_q - Lw'(1);
            end else if (full) begin
              fail      = 1'b1;
              fail_code = itp_pkg::ErrOverflow;
            end else begin
              we           = 1'b1;
              level_d      = level_q + Lw'(1);
              last_op_d    = 1'b0;
              prev_d       = itp_pkg::ClsOther;
              finish_quiet = 1'b1;
            end
          end
          itp_pkg::KindLparen: begin
            if (full) begin
              fail      = 1'b1;
              fail_code = itp_pkg::ErrOverflow;
            end else begin
              we           = 1'b1;
              wdata        = itp_pkg::StackLparen;
              level_d      = level_q + Lw'(1);
              open_d       = open_q + Lw'(1);
              prev_d       = itp_pkg::ClsLparen;
              finish_quiet = 1'b1;
            end
          end
          itp_pkg::KindRparen: begin
            if (open_q == '0) begin
              fail      = 1'b1;
              fail_code = itp_pkg::ErrNoLparen;
            end else if ((prev_q == itp_pkg::ClsLparen) && seen_q) begin
              fail      = 1'b1;
              fail_code = itp_pkg::ErrEmptyParens;
            end else if (!nonempty) begin
              fail      = 1'b1;
              fail_code = itp_pkg::ErrUnmatched;
            end else if (top != itp_pkg::StackLparen) begin
              emit_mid = 1'b1;
              level_d  = level_q - Lw'(1);
            end else begin
              level_d      = level_q - Lw'(1);
              open_d       = open_q - Lw'(1);
              prev_d       = itp_pkg::ClsRparen;
              finish_quiet = 1'b1;
            end
          end
          itp_pkg::KindOperand: begin
            if (last_op_q || (prev_q == itp_pkg::ClsRparen)) begin
              fail      = 1'b1;
              fail_code = itp_pkg::ErrOperandUnexpected;
            end else begin
              emit_final = 1'b1;
              final_res  = '{kind: itp_pkg::OutOperand, operand_ref: tok_ref_q,
                             err: itp_pkg::ErrOk};
              last_op_d  = 1'b1;
              seen_d     = 1'b1;
              prev_d     = itp_pkg::ClsOther;
            end
          end
          itp_pkg::KindEnd: begin
            fail_at_end = 1'b1;
            if (!seen_q) begin
              fail      = 1'b1;
              fail_code = itp_pkg::ErrEmpty;
            end else if (!last_op_q) begin
              fail      = 1'b1;
              fail_code = itp_pkg::ErrOpEnds;
            end else if (open_q != '0) begin
              fail      = 1'b1;
              fail_code = itp_pkg::ErrNoRparen;
            end else if (nonempty) begin
              emit_mid = 1'b1;
              level_d  = level_q - Lw'(1);
            end else begin
              emit_final = 1'b1;
              last_op_d  = 1'b0;
              prev_d     = itp_pkg::ClsNone;
              seen_d     = 1'b0;
            end
          end
          default: begin
            fail      = 1'b1;
            fail_code = itp_pkg::ErrIllegal;
          end
        endcase

        if (fail) begin
          emit_final = 1'b1;
          final_res  = '{kind: itp_pkg::OutError, operand_ref: 16'd0, err: fail_code};
          level_d    = '0;
          open_d     = '0;
          last_op_d  = 1'b0;
          prev_d     = itp_pkg::ClsNone;
          seen_d     = 1'b0;
          discard_d  = !fail_at_end;
        end
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    hold_d       = hold_q;
    hold_valid_d = hold_valid_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StRun;
        end
      end
      StRun: begin
        if (emit_mid) begin
          if (hold_valid_q) begin
            out_d       = hold_q;
            out_last_d  = 1'b0;
            out_valid_d = 1'b1;
          end
          hold_d       = mid_res;
          hold_valid_d = 1'b1;
        end else if (emit_final) begin
          if (hold_valid_q) begin
            out_d       = hold_q;
            out_last_d  = 1'b0;
            out_valid_d = 1'b1;
            hold_d      = final_res;
            state_d     = StFlush;
          end else begin
            out_d       = final_res;
            out_last_d  = 1'b1;
            out_valid_d = 1'b1;
            state_d     = StIdle;
          end
        end else if (finish_quiet) begin
          state_d = hold_valid_q ? StFlush : StIdle;
        end
      end
      StFlush: begin
        if (out_free) begin
          out_d        = hold_q;
          out_last_d   = 1'b1;
          out_valid_d  = 1'b1;
          hold_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      level_q      <= '0;
      open_q       <= '0;
      last_op_q    <= 1'b0;
      prev_q       <= itp_pkg::ClsNone;
      seen_q       <= 1'b0;
      discard_q    <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      level_q      <= level_d;
      open_q       <= open_d;
      last_op_q    <= last_op_d;
      prev_q       <= prev_d;
      seen_q       <= seen_d;
      discard_q    <= discard_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tok_kind_q <= token_kind_i;
      tok_ref_q  <= operand_ref_i;
    end
    hold_q     <= hold_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= Lw'(itp_pkg::StackDepth))
    else $error("stack level beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= level_q)
    else $error("more open parens than stacked entries");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !hold_valid_q)
    else $error("staged result left behind at idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun && discard_q) |=> (!hold_valid_q && $stable(level_q)))
    else $error("discarded item changed stack or staged a result");

endmodule

// ----- rtl/core/itp_stack_ram.sv -----
module itp_stack_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 3,
  parameter int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // forward a same-cycle write to the read port
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- tb/infix_to_postfix_converter_tb.sv -----
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;

  localparam logic [3:0] KindMul = 4'd1;
  localparam logic [3:0] KindDiv = 4'd2;
  localparam logic [3:0] KindAdd = 4'd3;
  localparam logic [3:0] KindSub = 4'd4;
  localparam logic [3:0] KindIllegal = 4'd9;
  localparam logic [3:0] KindMaxCode = 4'd15;
  localparam int DrainCycles = 64;
  localparam int HoldCycles = 300;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] oref;
    logic [3:0]  err;
    logic        last;
  } postfix_item_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [itp_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [itp_pkg::PrioW-1:0]    cfg_data_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [3:0]                   token_kind_i;
  logic [15:0]                  operand_ref_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [3:0]                   out_kind_o;
  logic [15:0]                  out_operand_ref_o;
  logic [3:0]                   error_code_o;
  logic                         last_o;

  infix_to_postfix_converter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .token_kind_i     (token_kind_i),
    .operand_ref_i    (operand_ref_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_kind_o       (out_kind_o),
    .out_operand_ref_o(out_operand_ref_o),
    .error_code_o     (error_code_o),
    .last_o           (last_o)
  );

  postfix_item_t postfix_q[$];
  postfix_item_t got_item;
  postfix_item_t want_item;

  logic [itp_pkg::PrioW-1:0] in_prio_tbl = itp_pkg::InPrioReset;
  logic [itp_pkg::PrioW-1:0] stack_prio_tbl = itp_pkg::StackPrioReset;
  logic [2:0]                op_stack [itp_pkg::StackDepth];
  int                        stack_level = 0;
  int                        open_parens = 0;
  bit                        operand_last = 1'b0;
  itp_pkg::cls_e             prev_cls = itp_pkg::ClsNone;
  bit                        output_seen = 1'b0;
  bit                        discarding = 1'b0;
  int                        produced;

  int mismatches = 0;
  int tokens_sent = 0;
  int cycle_count = 0;
  int hold_len = 0;
  bit idle_on = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [3:0] prio_of(logic [itp_pkg::PrioW-1:0] tbl, logic [2:0] code);
    return tbl[code*4 +: 4];
  endfunction

  function automatic void push_result(logic [3:0] kind, logic [15:0] oref, logic [3:0] err);
    postfix_item_t r;
    r.kind = kind;
    r.oref = oref;
    r.err = err;
    r.last = 1'b0;
    postfix_q.push_back(r);
    produced++;
  endfunction

  function automatic void clear_expression();
    stack_level = 0;
    open_parens = 0;
    operand_last = 1'b0;
    prev_cls = itp_pkg::ClsNone;
    output_seen = 1'b0;
  endfunction

  function automatic void reject(logic [3:0] err, bit at_end);
    push_result(itp_pkg::OutError, 16'h0000, err);
    clear_expression();
    discarding = !at_end;
  endfunction

  function automatic bit stack_push(logic [2:0] code);
    if (stack_level >= itp_pkg::StackDepth) return 1'b0;
    op_stack[stack_level] = code;
    stack_level++;
    return 1'b1;
  endfunction

  function automatic void predict_token(logic [3:0] kind, logic [15:0] oref);
    logic [3:0] in_prio;
    logic [2:0] top;
    produced = 0;
    if (discarding) begin
      if (kind == itp_pkg::KindEnd) discarding = 1'b0;
      return;
    end
    if (kind <= itp_pkg::KindAssign) begin
      in_prio = prio_of(in_prio_tbl, kind[2:0]);
      if (!operand_last || !output_seen || prev_cls == itp_pkg::ClsLparen) begin
        reject(itp_pkg::ErrOpUnexpected, 1'b0);
      end else begin
        while (stack_level > 0) begin
          top = op_stack[stack_level-1];
          if (top > itp_pkg::StackLastOp) break;
          if (in_prio > prio_of(stack_prio_tbl, top)) break;
          push_result({1'b0, top}, 16'h0000, itp_pkg::ErrOk);
          stack_level--;
        end
        if (!stack_push(kind[2:0])) begin
          reject(itp_pkg::ErrOverflow, 1'b0);
        end else begin
          operand_last = 1'b0;
          prev_cls = itp_pkg::ClsOther;
        end
      end
    end else if (kind == itp_pkg::KindLparen) begin
      if (!stack_push(itp_pkg::StackLparen)) begin
        reject(itp_pkg::ErrOverflow, 1'b0);
      end else begin
        open_parens++;
        prev_cls = itp_pkg::ClsLparen;
      end
    end else if (kind == itp_pkg::KindRparen) begin
      if (open_parens == 0) begin
        reject(itp_pkg::ErrNoLparen, 1'b0);
      end else if (prev_cls == itp_pkg::ClsLparen && output_seen) begin
        reject(itp_pkg::ErrEmptyParens, 1'b0);
      end else begin
        while (stack_level > 0 && op_stack[stack_level-1] != itp_pkg::StackLparen) begin
          push_result({1'b0, op_stack[stack_level-1]}, 16'h0000, itp_pkg::ErrOk);
          stack_level--;
        end
        if (stack_level == 0) begin
          reject(itp_pkg::ErrUnmatched, 1'b0);
        end else begin
          stack_level--;
          open_parens--;
          prev_cls = itp_pkg::ClsRparen;
        end
      end
    end else if (kind == itp_pkg::KindOperand) begin
      if (operand_last || prev_cls == itp_pkg::ClsRparen) begin
        reject(itp_pkg::ErrOperandUnexpected, 1'b0);
      end else begin
        push_result(itp_pkg::OutOperand, oref, itp_pkg::ErrOk);
        operand_last = 1'b1;
        output_seen = 1'b1;
        prev_cls = itp_pkg::ClsOther;
      end
    end else if (kind == itp_pkg::KindEnd) begin
      if (!output_seen) begin
        reject(itp_pkg::ErrEmpty, 1'b1);
      end else if (!operand_last) begin
        reject(itp_pkg::ErrOpEnds, 1'b1);
      end else if (open_parens > 0) begin
        reject(itp_pkg::ErrNoRparen, 1'b1);
      end else begin
        while (stack_level > 0) begin
          push_result({1'b0, op_stack[stack_level-1]}, 16'h0000, itp_pkg::ErrOk);
          stack_level--;
        end
        push_result(itp_pkg::OutEnd, 16'h0000, itp_pkg::ErrOk);
        clear_expression();
      end
    end else begin
      reject(itp_pkg::ErrIllegal, 1'b0);
    end
    if (produced > 0) postfix_q[$].last = 1'b1;
  endfunction

  function automatic void flag_mismatch(string what, postfix_item_t want, postfix_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected kind=%0d ref=%h err=%0d last=%b", $realtime, what,
               want.kind, want.oref, want.err, want.last);
      $display("%0t %s: actual   kind=%0d ref=%h err=%0d last=%b", $realtime, what,
               got.kind, got.oref, got.err, got.last);
    end
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_item = '{kind: out_kind_o, oref: out_operand_ref_o, err: error_code_o, last: last_o};
      if (postfix_q.size() == 0) begin
        flag_mismatch("unexpected item", '0, got_item);
      end else begin
        want_item = postfix_q.pop_front();
        if (got_item.kind != want_item.kind || got_item.oref != want_item.oref ||
            got_item.err != want_item.err || got_item.last != want_item.last) begin
          flag_mismatch("item mismatch", want_item, got_item);
        end
      end
    end
  end

  initial begin : receiver
    int gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (hold_len > 0) begin
        gap = hold_len;
        hold_len = 0;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  task automatic send_token(input logic [3:0] kind, input logic [15:0] oref);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    token_kind_i <= kind;
    operand_ref_i <= oref;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_token(kind, oref);
    tokens_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (postfix_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_priorities(input logic [itp_pkg::PrioW-1:0] in_tbl,
                                input logic [itp_pkg::PrioW-1:0] st_tbl);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= itp_pkg::CfgInPrio;
    cfg_data_i <= in_tbl;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    in_prio_tbl = in_tbl;
    @(negedge clk_i);
    cfg_index_i <= itp_pkg::CfgStackPrio;
    cfg_data_i <= st_tbl;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    stack_prio_tbl = st_tbl;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_expression(input bit noisy);
    int depth;
    int operands;
    bit want_operand;
    depth = 0;
    want_operand = 1'b1;
    operands = $urandom_range(1, 8);
    while (operands > 0) begin
      if (noisy && $urandom_range(0, 19) == 0)
        send_token(4'($urandom_range(0, KindMaxCode)), 16'($urandom));
      if (want_operand) begin
        if ($urandom_range(0, 3) == 0) begin
          send_token(itp_pkg::KindLparen, 16'($urandom));
          depth++;
        end else begin
          send_token(itp_pkg::KindOperand, 16'($urandom));
          want_operand = 1'b0;
          operands--;
        end
      end else if (depth > 0 && $urandom_range(0, 2) == 0) begin
        send_token(itp_pkg::KindRparen, 16'($urandom));
        depth--;
      end else begin
        send_token(4'($urandom_range(itp_pkg::KindPow, itp_pkg::KindAssign)), 16'($urandom));
        want_operand = 1'b1;
      end
    end
    if (!(noisy && $urandom_range(0, 9) == 0))
      repeat (depth) send_token(itp_pkg::KindRparen, 16'($urandom));
    send_token(itp_pkg::KindEnd, 16'($urandom));
  endtask

  task automatic run_expressions(input int count);
    int target;
    target = tokens_sent + count;
    while (tokens_sent < target) send_expression(1'b1);
  endtask

  task automatic test_precedence();
    send_token(itp_pkg::KindOperand, 16'h0000);
    send_token(itp_pkg::KindPow, 16'h0000);
    send_token(itp_pkg::KindOperand, 16'hFFFF);
    send_token(itp_pkg::KindPow, 16'h0000);
    send_token(itp_pkg::KindOperand, 16'h1234);
    send_token(KindMul, 16'h0000);
    send_token(itp_pkg::KindOperand, 16'h5A5A);
    send_token(KindDiv, 16'h0000);
    send_token(itp_pkg::KindOperand, 16'hA5A5);
    send_token(KindAdd, 16'h0000);
    send_token(itp_pkg::KindOperand, 16'h0001);
    send_token(KindSub, 16'h0000);
    send_token(itp_pkg::KindOperand, 16'h8000);
    send_token(itp_pkg::KindAssign, 16'h0000);
    send_token(itp_pkg::KindOperand, 16'h7FFF);
    send_token(itp_pkg::KindEnd, 16'h0000);
    send_token(itp_pkg::KindLparen, 16'h0000);
    send_token(itp_pkg::KindOperand, 16'h0002);
    send_token(KindAdd, 16'h0000);
    send_token(itp_pkg::KindOperand, 16'h0003);
    send_token(itp_pkg::KindRparen, 16'h0000);
    send_token(KindMul, 16'h0000);
    send_token(itp_pkg::KindOperand, 16'h0004);
    send_token(itp_pkg::KindEnd, 16'h0000);
  endtask

  task automatic test_syntax_errors();
    send_token(KindAdd, 16'h0000);
    send_token(itp_pkg::KindOperand, 16'hFFFF);
    send_token(itp_pkg::KindEnd, 16'h0000);
    send_token(itp_pkg::KindRparen, 16'h0000);
    send_token(itp_pkg::KindEnd, 16'h0000);
    send_token(itp_pkg::KindOperand, 16'h0011);
    send_token(KindMul, 16'h0000);
    send_token(itp_pkg::KindLparen, 16'h0000);
    send_token(itp_pkg::KindRparen, 16'h0000);
    send_token(itp_pkg::KindEnd, 16'h0000);
    send_token(itp_pkg::KindLparen, 16'h0000);
    send_token(itp_pkg::KindRparen, 16'h0000);
    send_token(itp_pkg::KindEnd, 16'h0000);
    send_token(itp_pkg::KindOperand, 16'h0022);
    send_token(itp_pkg::KindOperand, 16'h0033);
    send_token(itp_pkg::KindEnd, 16'h0000);
    send_token(itp_pkg::KindLparen, 16'h0000);
    send_token(itp_pkg::KindOperand, 16'h0044);
    send_token(itp_pkg::KindRparen, 16'h0000);
    send_token(itp_pkg::KindOperand, 16'h0055);
    send_token(itp_pkg::KindEnd, 16'h0000);
    send_token(itp_pkg::KindOperand, 16'h0066);
    send_token(KindIllegal, 16'h0000);
    send_token(itp_pkg::KindEnd, 16'h0000);
    send_token(KindMaxCode, 16'h0000);
    send_token(itp_pkg::KindEnd, 16'h0000);
    send_token(itp_pkg::KindEnd, 16'h0000);
    send_token(itp_pkg::KindOperand, 16'h0077);
    send_token(KindSub, 16'h0000);
    send_token(itp_pkg::KindEnd, 16'h0000);
    send_token(itp_pkg::KindLparen, 16'h0000);
    send_token(itp_pkg::KindOperand, 16'h0088);
    send_token(itp_pkg::KindEnd, 16'h0000);
  endtask

  task automatic test_stack_overflow();
    repeat (itp_pkg::StackDepth + 1) send_token(itp_pkg::KindLparen, 16'h0000);
    send_token(itp_pkg::KindEnd, 16'h0000);
    repeat (itp_pkg::StackDepth - 1) send_token(itp_pkg::KindLparen, 16'h0000);
    send_token(itp_pkg::KindOperand, 16'h0099);
    send_token(KindAdd, 16'h0000);
    send_token(itp_pkg::KindOperand, 16'h00AA);
    send_token(KindMul, 16'h0000);
    send_token(itp_pkg::KindEnd, 16'h0000);
  endtask

  task automatic test_priority_settings();
    run_expressions(25);
    wait_drained();
    set_priorities('0, '0);
    run_expressions(25);
    wait_drained();
    set_priorities('1, '1);
    run_expressions(25);
    wait_drained();
    set_priorities('1, '0);
    run_expressions(25);
    wait_drained();
    set_priorities('0, '1);
    run_expressions(25);
    wait_drained();
    set_priorities(itp_pkg::PrioW'($urandom), itp_pkg::PrioW'($urandom));
    run_expressions(25);
    wait_drained();
    set_priorities(itp_pkg::InPrioReset, itp_pkg::StackPrioReset);
  endtask

  task automatic test_output_backpressure();
    idle_on = 1'b0;
    hold_len = HoldCycles;
    run_expressions(40);
    idle_on = 1'b1;
  endtask

  task automatic test_random_mix();
    idle_on = 1'b0;
    run_expressions(30);
    idle_on = 1'b1;
    run_expressions(30);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    token_kind_i = '0;
    operand_ref_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_precedence();
    test_syntax_errors();
    test_stack_overflow();
    test_priority_settings();
    test_output_backpressure();
    test_random_mix();
    wait_drained();
    if (mismatches == 0 && postfix_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/itp_pkg.sv
rtl/core/itp_stack_ram.sv
rtl/core/infix_to_postfix_converter.sv
tb/infix_to_postfix_converter_tb.sv
